### rtl/core/dscd_pkg.sv
package dscd_pkg;

	// Field widths of the stream items.
	localparam int DIGIT_COUNT_W = 6;
	localparam int DIGIT_SUM_W   = 8;
	localparam int COUNT_W       = 63;
	localparam int IN_DATA_W     = 16;
	localparam int OUT_DATA_W    = 64;

	// Largest decimal digit, and the length of the sliding window over a row.
	localparam int DIGIT_MAX = 9;
	localparam int WIN_LEN   = DIGIT_MAX + 1;

	// Defaults for the top-level parameters.
	localparam int MAX_DIGITS_DEF = 32;
	localparam int MAX_SUM_DEF    = 255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_GAP,
		ST_DONE
	} dscd_state_t;

endpackage

### rtl/core/digit_sum_count_dp.sv
// Counts the n-digit decimal strings (leading zeros allowed) whose digits add up to k, with n
// and k taken from one input item and clamped to MAX_DIGITS and MAX_SUM. The table rows live
// in one ping-pong memory; each cell of a row is formed with a running ten-entry window sum
// over the row before, one cell per cycle while a row is in progress, set by the single read
// and write port of that memory. Items with n of 0 or 1 need no table. When a table entry goes
// past 2^63-1 the work stops early and the result carries count 0 with overflow set. A new
// item is taken only after the previous result has been handed to the output register.
module digit_sum_count_dp
	import dscd_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int MAX_SUM    = MAX_SUM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // digit_count [5:0], digit_sum [13:6], zeros
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // count [62:0], overflow [63]
);

	localparam int SW     = $clog2(MAX_SUM + 1);
	localparam int RW_RAW = $clog2(MAX_DIGITS + 1);
	localparam int RW     = (RW_RAW < 2) ? 2 : RW_RAW;
	localparam int AW     = SW + 1;
	localparam int DEPTH  = 2 ** AW;

	dscd_state_t state_q, state_d;

	logic [DIGIT_COUNT_W-1:0] in_n;
	logic [DIGIT_SUM_W-1:0]   in_k;
	logic [RW-1:0]            n_eff;
	logic [SW-1:0]            k_eff;
	logic                     in_fire;

	logic [RW-1:0]      n_q;
	logic [RW-1:0]      row_q;
	logic [SW-1:0]      k_q;
	logic [SW-1:0]      s_q;
	logic               bank_q;
	logic               ovf_q;
	logic [COUNT_W-1:0] win_q;
	logic [COUNT_W-1:0] taps_q [WIN_LEN];

	logic               rd_valid_s1;
	logic [SW-1:0]      s_s1;
	logic [COUNT_W-1:0] rd_s1;

	logic [COUNT_W-1:0] row_mem [DEPTH];

	logic [COUNT_W-1:0]    cell_in;
	logic [COUNT_W:0]      w_new;
	logic                  ovf_now;
	logic                  next_row;
	logic                  finish;
	logic                  out_load;
	logic [COUNT_W-1:0]    fin_count_q;
	logic                  fin_ovf_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign in_n = s_tdata[DIGIT_COUNT_W-1:0];
	assign in_k = s_tdata[DIGIT_COUNT_W +: DIGIT_SUM_W];

	always_comb begin
		if (32'(in_n) > 32'(MAX_DIGITS)) begin
			n_eff = RW'(MAX_DIGITS);
		end else begin
			n_eff = RW'(in_n);
		end
		if (32'(in_k) > 32'(MAX_SUM)) begin
			k_eff = SW'(MAX_SUM);
		end else begin
			k_eff = SW'(in_k);
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// The first row is all ones up to nine, so it is generated rather than read back.
	always_comb begin
		if (row_q == RW'(2)) begin
			cell_in = (32'(s_s1) <= 32'(DIGIT_MAX)) ? COUNT_W'(1) : '0;
		end else begin
			cell_in = rd_s1;
		end
	end

	// The window never holds more than the limit, so one extra bit catches overflow.
	assign w_new   = {1'b0, win_q} + {1'b0, cell_in} - {1'b0, taps_q[WIN_LEN-1]};
	assign ovf_now = rd_valid_s1 && !ovf_q && w_new[COUNT_W];

	always_comb begin
		state_d  = state_q;
		next_row = 1'b0;
		finish   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (n_eff <= RW'(1)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (s_q == k_q) begin
					state_d = ST_GAP;
				end
			end
			ST_GAP: begin
				if (ovf_q || ovf_now || row_q == n_q) begin
					state_d = ST_DONE;
					finish  = 1'b1;
				end else begin
					state_d  = ST_RUN;
					next_row = 1'b1;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d  = ST_IDLE;
					out_load = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= (state_q == ST_RUN);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Row memory: read the previous row from one bank, write the new row to the other.
	always_ff @(posedge clk) begin
		if (state_q == ST_RUN) begin
			rd_s1 <= row_mem[{bank_q, s_q}];
		end
		if (rd_valid_s1) begin
			row_mem[{~bank_q, s_s1}] <= w_new[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		s_s1 <= s_q;
		if (state_q == ST_RUN) begin
			s_q <= s_q + SW'(1);
		end
		// The window starts empty for every row.
		if (next_row || in_fire) begin
			win_q <= '0;
			for (int i = 0; i < WIN_LEN; i++) begin
				taps_q[i] <= '0;
			end
		end else if (rd_valid_s1 && !ovf_q) begin
			win_q     <= w_new[COUNT_W-1:0];
			taps_q[0] <= cell_in;
			for (int i = 1; i < WIN_LEN; i++) begin
				taps_q[i] <= taps_q[i-1];
			end
		end
		if (ovf_now) begin
			ovf_q <= 1'b1;
		end
		if (finish) begin
			fin_ovf_q   <= ovf_q || ovf_now;
			fin_count_q <= (ovf_q || ovf_now) ? '0 : w_new[COUNT_W-1:0];
		end
		if (next_row) begin
			row_q  <= row_q + RW'(1);
			bank_q <= ~bank_q;
			s_q    <= '0;
		end
		if (in_fire) begin
			n_q    <= n_eff;
			k_q    <= k_eff;
			row_q  <= RW'(2);
			s_q    <= '0;
			bank_q <= 1'b0;
			ovf_q  <= 1'b0;
			// Zero or one digit needs no table.
			fin_ovf_q <= 1'b0;
			if (n_eff == '0) begin
				fin_count_q <= (k_eff == '0) ? COUNT_W'(1) : '0;
			end else begin
				fin_count_q <= (32'(k_eff) <= 32'(DIGIT_MAX)) ? COUNT_W'(1) : '0;
			end
		end
		if (out_load) begin
			m_tdata_q <= {fin_ovf_q, fin_count_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dscd_pkg::*;

	localparam logic [63:0] ENTRY_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int          CYCLE_LIMIT = 4_000_000;
	localparam int          RANDOM_ITEMS = 100;

	typedef struct packed {
		logic [1:0]               pad;
		logic [DIGIT_SUM_W-1:0]   digit_sum;
		logic [DIGIT_COUNT_W-1:0] digit_count;
	} count_req_t;

	typedef struct packed {
		logic               overflow;
		logic [COUNT_W-1:0] count;
	} digit_result_t;

	typedef struct {
		count_req_t req;
		bit         drain_first;
	} pending_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	pending_req_t  request_queue[$];
	digit_result_t expected_counts[$];

	int in_presented = 0;
	int in_accepted  = 0;
	int out_taken    = 0;
	int out_seen     = 0;
	int feed_gap     = 0;
	int sink_stall   = 0;
	int calm_left    = 0;
	int mismatches   = 0;
	int cycle_count  = 0;

	digit_sum_count_dp DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Row-by-row count of digit strings, two rows kept, stopping at the first entry past 2^63-1.
	function automatic digit_result_t count_strings(input logic [DIGIT_COUNT_W-1:0] n_in,
			input logic [DIGIT_SUM_W-1:0] k_in);
		logic [63:0]   prev_row [0:MAX_SUM_DEF];
		logic [63:0]   cur_row  [0:MAX_SUM_DEF];
		logic [63:0]   acc;
		int            n, k, r, s, d;
		bit            ovf;
		digit_result_t res;
		n   = (n_in > MAX_DIGITS_DEF) ? MAX_DIGITS_DEF : n_in;
		k   = (k_in > MAX_SUM_DEF) ? MAX_SUM_DEF : k_in;
		ovf = 1'b0;
		res = '0;
		if (n == 0) begin
			res.count = (k == 0) ? COUNT_W'(1) : '0;
			return res;
		end
		for (s = 0; s <= k; s++)
			prev_row[s] = (s <= DIGIT_MAX) ? 64'd1 : 64'd0;
		for (r = 2; r <= n && !ovf; r++) begin
			for (s = 0; s <= k && !ovf; s++) begin
				acc = '0;
				for (d = 0; d <= DIGIT_MAX && d <= s; d++) begin
					acc += prev_row[s - d];
					if (acc > ENTRY_MAX) begin
						ovf = 1'b1;
						break;
					end
				end
				cur_row[s] = acc;
			end
			if (!ovf) begin
				for (s = 0; s <= k; s++)
					prev_row[s] = cur_row[s];
			end
		end
		res.overflow = ovf;
		res.count    = ovf ? '0 : prev_row[k][COUNT_W-1:0];
		return res;
	endfunction

	// Idle cycles before the next item on either side; now and then a run of items with none.
	function int draw_wait();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm_left = $urandom_range(5, 15);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function void add_request(input int n, input int k, input bit drain);
		pending_req_t p;
		p.req             = '0;
		p.req.digit_count = DIGIT_COUNT_W'(n);
		p.req.digit_sum   = DIGIT_SUM_W'(k);
		p.drain_first     = drain;
		request_queue.push_back(p);
	endfunction

	always @(negedge clk) begin : feed_proc
		logic         valid_next;
		count_req_t   data_next;
		pending_req_t p;
		valid_next = s_tvalid;
		data_next  = s_tdata;
		if (!arst_n) begin
			valid_next = 1'b0;
		end else begin
			if (s_tvalid && in_accepted == in_presented) begin
				valid_next = 1'b0;
				feed_gap   = draw_wait();
			end
			if (!valid_next) begin
				if (feed_gap > 0) begin
					feed_gap--;
				end else if (request_queue.size() > 0 &&
						(!request_queue[0].drain_first || expected_counts.size() == 0)) begin
					p          = request_queue.pop_front();
					data_next  = p.req;
					valid_next = 1'b1;
					in_presented++;
				end
			end
		end
		s_tvalid <= valid_next;
		s_tdata  <= data_next;
	end

	always @(negedge clk) begin : sink_proc
		if (out_taken != out_seen) begin
			out_seen   = out_taken;
			sink_stall = draw_wait();
		end
		m_tready <= (sink_stall == 0);
		if (m_tvalid && sink_stall > 0)
			sink_stall--;
	end

	always @(posedge clk) begin : check_proc
		count_req_t    req;
		digit_result_t got;
		digit_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				req = s_tdata;
				expected_counts.push_back(count_strings(req.digit_count, req.digit_sum));
				in_accepted++;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				out_taken++;
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected item: expected none, got count %0d overflow %0b",
						$time, got.count, got.overflow);
					mismatches++;
				end else begin
					want = expected_counts.pop_front();
					if (got.count !== want.count) begin
						$display("%0t: count mismatch: expected %0d, got %0d",
							$time, want.count, got.count);
						mismatches++;
					end
					if (got.overflow !== want.overflow) begin
						$display("%0t: overflow mismatch: expected %0b, got %0b",
							$time, want.overflow, got.overflow);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stim_proc
		int i, n, k, pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;

		// Zero digits, single digit edges, saturated digit count, zero target.
		add_request(0, 0, 0);
		add_request(0, 5, 0);
		add_request(1, 0, 0);
		add_request(1, 9, 0);
		add_request(1, 10, 0);
		add_request(1, 255, 0);
		add_request(63, 0, 0);
		add_request(5, 0, 0);
		add_request(2, 18, 0);
		add_request(2, 19, 0);
		add_request(3, 13, 0);
		add_request(7, 31, 0);
		add_request(6, 255, 0);
		add_request(32, 1, 0);
		// Largest counts that still fit, then the first overflowing row.
		add_request(20, 90, 0);
		add_request(21, 94, 0);
		add_request(32, 144, 0);
		add_request(32, 255, 0);
		add_request(42, 170, 0);
		add_request(63, 255, 0);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				n = $urandom_range(0, 6);
				k = $urandom_range(0, 60);
			end else if (pick < 17) begin
				n = $urandom_range(0, 20);
				k = $urandom_range(0, 120);
			end else if (pick == 17) begin
				// Near the middle of a long row, where entries come close to the limit.
				n = $urandom_range(19, 32);
				k = (9 * n) / 2 - 15 + $urandom_range(0, 30);
			end else begin
				n = $urandom_range(0, 63);
				k = $urandom_range(0, 255);
			end
			add_request(n, k, (i == 0) || ($urandom_range(0, 14) == 0));
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() > 0 || s_tvalid || expected_counts.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		if (mismatches == 0 && expected_counts.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/core/dscd_pkg.sv
rtl/core/digit_sum_count_dp.sv
dv/testbench.sv
